// ----- rtl/cgs_pkg.sv -----
// ----------------------------------------------------------------------------
// cgs_pkg
// shared constants, types and helpers of the combination gray code stepper
// ----------------------------------------------------------------------------
package cgs_pkg;

  localparam int unsigned PatW       = 64;
  localparam int unsigned PosW       = 6;
  localparam int unsigned CountW     = 7;
  localparam int unsigned MaxSetSize = 64;

  localparam logic        KindLoad    = 1'b0;
  localparam logic        KindAdvance = 1'b1;

  localparam logic [1:0]  StatusStep  = 2'd0;
  localparam logic [1:0]  StatusHold  = 2'd1;
  localparam logic [1:0]  StatusErr   = 2'd2;

  typedef struct packed {
    logic            valid;
    logic            err;
    logic [PosW-1:0] pos1;
    logic [PosW-1:0] pos2;
  } flip_res_t;

  function automatic logic [PatW-1:0] low_mask(input logic [CountW-1:0] cnt);
    logic [PatW-1:0] m;
    if (cnt >= CountW'(PatW)) begin
      m = '1;
    end else begin
      m = (PatW'(1) << cnt) - PatW'(1);
    end
    return m;
  endfunction

endpackage

// ----- rtl/cgs_core.sv -----
// ----------------------------------------------------------------------------
// cgs_core
// bit-serial scan sequencer that finds the two positions of the next step
// ----------------------------------------------------------------------------
module cgs_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [cgs_pkg::PatW-1:0]       pattern_i,
  input  logic [cgs_pkg::CountW-1:0]     set_size_i,
  input  logic [cgs_pkg::CountW-1:0]     choose_count_i,
  output cgs_pkg::flip_res_t             res_o
);

  typedef enum logic [4:0] {
    C_IDLE   = 5'b00001,
    C_UP     = 5'b00010,
    C_RUN    = 5'b00100,
    C_DECIDE = 5'b01000,
    C_SET    = 5'b10000
  } core_state_e;

  core_state_e                  state_q, state_d;
  logic [cgs_pkg::PosW-1:0]     pos_q, pos_d;
  logic [cgs_pkg::PosW-1:0]     j1_q, j1_d;
  logic                         top_q, top_d;

  logic [cgs_pkg::CountW-1:0]   nm1, nm2, nj, nj1, nj2, njp1, nmm;
  logic                         bit_cur, bit_prev, bit_nj1, bit_nj2;
  logic [cgs_pkg::PosW-1:0]     pos_prev;

  assign nm1      = set_size_i - cgs_pkg::CountW'(1);
  assign nm2      = set_size_i - cgs_pkg::CountW'(2);
  assign nj       = set_size_i - {1'b0, j1_q};
  assign nj1      = nj - cgs_pkg::CountW'(1);
  assign nj2      = nj - cgs_pkg::CountW'(2);
  assign njp1     = nj + cgs_pkg::CountW'(1);
  assign nmm      = set_size_i - choose_count_i;
  assign pos_prev = pos_q - cgs_pkg::PosW'(1);
  assign bit_cur  = pattern_i[pos_q];
  assign bit_prev = pattern_i[pos_prev];
  assign bit_nj1  = pattern_i[nj1[cgs_pkg::PosW-1:0]];
  assign bit_nj2  = pattern_i[nj2[cgs_pkg::PosW-1:0]];

  always_comb begin
    state_d = state_q;
    pos_d   = pos_q;
    j1_d    = j1_q;
    top_d   = top_q;
    res_o   = '0;
    unique case (state_q)
      C_IDLE: begin
        if (start_i) begin
          if (choose_count_i == cgs_pkg::CountW'(1)) begin
            pos_d   = '0;
            state_d = C_UP;
          end else begin
            pos_d   = nm2[cgs_pkg::PosW-1:0];
            top_d   = pattern_i[nm1[cgs_pkg::PosW-1:0]];
            state_d = C_RUN;
          end
        end
      end
      C_UP: begin
        if (bit_cur) begin
          res_o.valid = 1'b1;
          res_o.pos1  = pos_q;
          res_o.pos2  = (pos_q == nm1[cgs_pkg::PosW-1:0]) ? '0 : pos_q + cgs_pkg::PosW'(1);
          state_d     = C_IDLE;
        end else if (pos_q == nm1[cgs_pkg::PosW-1:0]) begin
          res_o.valid = 1'b1;
          res_o.err   = 1'b1;
          state_d     = C_IDLE;
        end else begin
          pos_d = pos_q + cgs_pkg::PosW'(1);
        end
      end
      C_RUN: begin
        if (bit_cur != top_q) begin
          j1_d    = nm1[cgs_pkg::PosW-1:0] - pos_q;
          state_d = C_DECIDE;
        end else if (pos_q == '0) begin
          j1_d    = '0;
          state_d = C_DECIDE;
        end else begin
          pos_d = pos_prev;
        end
      end
      C_DECIDE: begin
        if (top_q && (choose_count_i[0] ^ j1_q[0])) begin
          // trailing run forces a downward search for the next set bit
          if (nj1 == '0) begin
            res_o.valid = 1'b1;
            res_o.pos1  = '0;
            res_o.pos2  = nmm[cgs_pkg::PosW-1:0];
            state_d     = C_IDLE;
          end else begin
            pos_d   = nj1[cgs_pkg::PosW-1:0];
            state_d = C_SET;
          end
        end else begin
          res_o.valid = 1'b1;
          state_d     = C_IDLE;
          if (top_q) begin
            res_o.pos1 = nj1[cgs_pkg::PosW-1:0];
            res_o.pos2 = (j1_q < cgs_pkg::PosW'(2)) ? nm1[cgs_pkg::PosW-1:0]
                                                   : njp1[cgs_pkg::PosW-1:0];
          end else if (choose_count_i[0]) begin
            if (nj1 == '0) begin
              res_o.err = 1'b1;
            end else begin
              res_o.pos2 = nj2[cgs_pkg::PosW-1:0];
              res_o.pos1 = (bit_nj1 && bit_nj2) ? nm1[cgs_pkg::PosW-1:0]
                                                : nj1[cgs_pkg::PosW-1:0];
            end
          end else begin
            if (j1_q == '0) begin
              res_o.err = 1'b1;
            end else begin
              res_o.pos1 = nj1[cgs_pkg::PosW-1:0];
              res_o.pos2 = nj[cgs_pkg::PosW-1:0];
            end
          end
        end
      end
      C_SET: begin
        if (bit_cur) begin
          res_o.valid = 1'b1;
          res_o.pos1  = pos_prev;
          state_d     = C_IDLE;
          if (bit_prev) begin
            res_o.pos2 = nj1[cgs_pkg::PosW-1:0];
          end else if (j1_q == '0) begin
            res_o.err = 1'b1;
          end else begin
            res_o.pos2 = nj[cgs_pkg::PosW-1:0];
          end
        end else if (pos_q == cgs_pkg::PosW'(1)) begin
          res_o.valid = 1'b1;
          res_o.pos1  = '0;
          res_o.pos2  = nmm[cgs_pkg::PosW-1:0];
          state_d     = C_IDLE;
        end else begin
          pos_d = pos_prev;
        end
      end
      default: begin
        state_d = C_IDLE;
      end
    endcase
    if (res_o.err) begin
      res_o.pos1 = '0;
      res_o.pos2 = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    j1_q  <= j1_d;
    top_q <= top_d;
  end

endmodule

// ----- rtl/combination_gray_code_stepper_top.sv -----
// ----------------------------------------------------------------------------
// combination_gray_code_stepper_top
// load, unchanged and oversized pool items go straight to the done state and the output register
// advance items are first scanned by the core, one pattern bit per cycle
// throughput: one item at a time, bound by the single-bit scan unit
// reset: pattern cleared, set_size 25, choose_count 1, no result pending
// ----------------------------------------------------------------------------
module combination_gray_code_stepper_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [cgs_pkg::CountW-1:0]   cfg_data_i,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [63:0]                  s_axis_tdata,  // load_pattern
  input  logic                         s_axis_tuser,  // kind
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  // pattern_out, first_flip, second_flip, status, at_start, zero pad
  output logic [79:0]                  m_axis_tdata
);

  typedef enum logic [2:0] {
    T_IDLE = 3'b001,
    T_BUSY = 3'b010,
    T_DONE = 3'b100
  } top_state_e;

  localparam logic CfgSetSize     = 1'b0;
  localparam logic CfgChooseCount = 1'b1;

  top_state_e                   state_q, state_d;
  logic [cgs_pkg::CountW-1:0]   set_size_q, choose_count_q;
  logic [cgs_pkg::PatW-1:0]     chosen_q, chosen_d;
  logic [1:0]                   status_q, status_d;
  logic [cgs_pkg::PosW-1:0]     f1_q, f1_d, f2_q, f2_d;
  logic                         flip_q, flip_d;
  logic                         start;
  cgs_pkg::flip_res_t           core_res;

  logic                         out_valid_q, out_valid_d;
  logic [cgs_pkg::PatW-1:0]     out_pat_q;
  logic [cgs_pkg::PosW-1:0]     out_f1_q, out_f2_q;
  logic [1:0]                   out_status_q;
  logic                         out_start_q;
  logic                         out_load;
  logic [cgs_pkg::PatW-1:0]     next_pat;
  logic                         in_xfer;

  assign s_axis_tready = (state_q == T_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_start_q, out_status_q, out_f2_q, out_f1_q, out_pat_q};

  assign next_pat = flip_q ? (chosen_q ^ (cgs_pkg::PatW'(1) << f1_q)
                                       ^ (cgs_pkg::PatW'(1) << f2_q))
                           : chosen_q;

  cgs_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .pattern_i      (chosen_q),
    .set_size_i     (set_size_q),
    .choose_count_i (choose_count_q),
    .res_o          (core_res)
  );

  always_comb begin
    state_d     = state_q;
    chosen_d    = chosen_q;
    status_d    = status_q;
    f1_d        = f1_q;
    f2_d        = f2_q;
    flip_d      = flip_q;
    start       = 1'b0;
    out_load    = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      T_IDLE: begin
        if (in_xfer) begin
          f1_d     = '0;
          f2_d     = '0;
          flip_d   = 1'b0;
          state_d  = T_DONE;
          if (s_axis_tuser == cgs_pkg::KindLoad) begin
            chosen_d = s_axis_tdata & cgs_pkg::low_mask(set_size_q);
            status_d = cgs_pkg::StatusStep;
          end else if (choose_count_q == '0 || choose_count_q >= set_size_q) begin
            status_d = cgs_pkg::StatusHold;
          end else if (set_size_q > cgs_pkg::CountW'(cgs_pkg::MaxSetSize)) begin
            status_d = cgs_pkg::StatusErr;
          end else begin
            start   = 1'b1;
            state_d = T_BUSY;
          end
        end
      end
      T_BUSY: begin
        if (core_res.valid) begin
          status_d = core_res.err ? cgs_pkg::StatusErr : cgs_pkg::StatusStep;
          flip_d   = !core_res.err;
          f1_d     = core_res.pos1;
          f2_d     = core_res.pos2;
          state_d  = T_DONE;
        end
      end
      T_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          chosen_d    = next_pat;
          state_d     = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= T_IDLE;
      set_size_q     <= cgs_pkg::CountW'(25);
      choose_count_q <= cgs_pkg::CountW'(1);
      chosen_q       <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q     <= state_d;
      chosen_q    <= chosen_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSetSize:     set_size_q     <= cfg_data_i;
          CfgChooseCount: choose_count_q <= cfg_data_i;
          default:        ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    f1_q     <= f1_d;
    f2_q     <= f2_d;
    flip_q   <= flip_d;
    if (out_load) begin
      out_pat_q    <= next_pat;
      out_f1_q     <= f1_q;
      out_f2_q     <= f2_q;
      out_status_q <= status_q;
      out_start_q  <= (next_pat == cgs_pkg::low_mask(choose_count_q));
    end
  end

endmodule

// ----- tb/cgs_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cgs_tb_pkg
// register indexes of the stepper's write port, shared by the bench files
// ----------------------------------------------------------------------------
package cgs_tb_pkg;

  localparam logic RegSetSize     = 1'b0;
  localparam logic RegChooseCount = 1'b1;

endpackage

// ----- tb/cgs_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cgs_checker
// watches the register port and both streams of the gray code stepper, keeps
// its own copy of the pattern and settings, and checks every result transfer
// against the oldest pending prediction, field by field
// ----------------------------------------------------------------------------
module cgs_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [cgs_pkg::CountW-1:0] cfg_data_i,
  input  logic                       in_valid_i,
  input  logic                       in_ready_i,
  input  logic [63:0]                in_data_i,
  input  logic                       in_user_i,
  input  logic                       out_valid_i,
  input  logic                       out_ready_i,
  input  logic [79:0]                out_data_i,
  output int                         errors_o,
  output int                         pending_o
);

  // most significant member first, pattern in the low bits
  typedef struct packed {
    logic        at_start;
    logic [1:0]  status;
    logic [5:0]  flip_b;
    logic [5:0]  flip_a;
    logic [63:0] pattern;
  } step_result_t;

  logic [63:0]                combo;
  logic [cgs_pkg::CountW-1:0] pool_size;
  logic [cgs_pkg::CountW-1:0] ones_wanted;
  step_result_t               step_q[$];
  int                         errors;
  int                         pending;

  assign errors_o  = errors;
  assign pending_o = pending;

  function automatic logic [63:0] ones_below(input int cnt);
    logic [63:0] r;
    r = '1;
    if (cnt < 64) begin
      r = ~(r << cnt);
    end
    return r;
  endfunction

  function automatic logic tap(input logic [63:0] p, input int pos);
    return p[pos & 63];
  endfunction

  // one-based positions of the two toggles of the revolving door step
  function automatic logic [1:0] locate_flips(input logic [63:0] p, input int n,
                                              input int m, output int k1,
                                              output int k2);
    int   j;
    int   j1;
    int   i;
    int   i1;
    int   jp;
    logic top;
    logic scan;
    j1   = 0;
    k1   = 0;
    k2   = 0;
    scan = 1'b0;
    top  = tap(p, n - 1);
    if (m == 1) begin
      for (i = 0; i < n; i++) begin
        if (tap(p, i)) begin
          k1 = i + 1;
          k2 = (i + 1 >= n) ? 1 : i + 2;
          return cgs_pkg::StatusStep;
        end
      end
      return cgs_pkg::StatusErr;
    end
    for (j = 1; j < n; j++) begin
      if (top != tap(p, n - j - 1)) begin
        j1 = j;
        break;
      end
    end
    if ((m & 1) != 0) begin
      if (top) begin
        if ((j1 & 1) != 0) begin
          k1 = n - j1;
          k2 = (k1 + 2 > n) ? n : k1 + 2;
        end else begin
          scan = 1'b1;
        end
      end else begin
        k2 = n - j1 - 1;
        if (k2 == 0) begin
          k1 = 0;
          k2 = n - j1;
        end else if (tap(p, k2) && tap(p, k2 - 1)) begin
          k1 = n;
        end else begin
          k1 = k2 + 1;
        end
      end
    end else begin
      if (!top) begin
        k1 = n - j1;
        k2 = k1 + 1;
      end else if ((j1 & 1) == 0) begin
        k1 = n - j1;
        k2 = (k1 + 2 > n) ? n : k1 + 2;
      end else begin
        scan = 1'b1;
      end
    end
    if (scan) begin
      jp = n - j1 - 1;
      k1 = 1;
      k2 = n + 1 - m;
      for (i = 1; i <= jp; i++) begin
        i1 = jp + 2 - i;
        if (tap(p, i1 - 1)) begin
          k1 = i1 - 1;
          k2 = tap(p, i1 - 2) ? (n - j1) : (n + 1 - j1);
          break;
        end
      end
    end
    if (k1 < 1 || k1 > n || k2 < 1 || k2 > n) begin
      return cgs_pkg::StatusErr;
    end
    return cgs_pkg::StatusStep;
  endfunction

  function automatic step_result_t apply_item(input logic kind, input logic [63:0] load);
    step_result_t r;
    int           k1;
    int           k2;
    r = '0;
    r.status = cgs_pkg::StatusStep;
    if (kind == cgs_pkg::KindLoad) begin
      combo = load & ones_below(pool_size);
    end else if (ones_wanted == 0 || ones_wanted >= pool_size) begin
      r.status = cgs_pkg::StatusHold;
    end else if (pool_size > cgs_pkg::MaxSetSize) begin
      r.status = cgs_pkg::StatusErr;
    end else begin
      r.status = locate_flips(combo, pool_size, ones_wanted, k1, k2);
      if (r.status == cgs_pkg::StatusStep) begin
        combo[(k1 - 1) & 63] = ~combo[(k1 - 1) & 63];
        combo[(k2 - 1) & 63] = ~combo[(k2 - 1) & 63];
        r.flip_a = 6'((k1 - 1) & 63);
        r.flip_b = 6'((k2 - 1) & 63);
      end
    end
    r.pattern  = combo;
    r.at_start = (combo == ones_below(ones_wanted));
    return r;
  endfunction

  task automatic report(input string what, input logic [63:0] got,
                        input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    step_result_t want;
    step_result_t got;
    if (!rst_ni) begin
      combo       = '0;
      pool_size   = 7'd25;
      ones_wanted = 7'd1;
      step_q.delete();
      errors      = 0;
      pending     = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == cgs_tb_pkg::RegSetSize) begin
          pool_size = cfg_data_i;
        end else begin
          ones_wanted = cfg_data_i;
        end
      end
      if (in_valid_i && in_ready_i) begin
        step_q.push_back(apply_item(in_user_i, in_data_i));
      end
      if (out_valid_i && out_ready_i) begin
        got = out_data_i[78:0];
        if (step_q.size() == 0) begin
          report("unexpected result", got.pattern, '0);
        end else begin
          want = step_q.pop_front();
          if (got.pattern !== want.pattern) begin
            report("pattern_out", got.pattern, want.pattern);
          end
          if (got.flip_a !== want.flip_a) begin
            report("first_flip", 64'(got.flip_a), 64'(want.flip_a));
          end
          if (got.flip_b !== want.flip_b) begin
            report("second_flip", 64'(got.flip_b), 64'(want.flip_b));
          end
          if (got.status !== want.status) begin
            report("status", 64'(got.status), 64'(want.status));
          end
          if (got.at_start !== want.at_start) begin
            report("at_start", 64'(got.at_start), 64'(want.at_start));
          end
        end
      end
      pending = step_q.size();
    end
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// regression of the combination gray code stepper: directed loads and steps
// over the corner settings, then random phases of well-formed combinations
// with stepping runs, load noise, random idling and one long output stall
// ----------------------------------------------------------------------------
module tb;

  localparam int Limit = 1_500_000;
  localparam int Items = 1040;

  logic                       clk_i = 1'b0;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we = 1'b0;
  logic                       cfg_idx = 1'b0;
  logic [cgs_pkg::CountW-1:0] cfg_data = '0;
  logic                       s_valid = 1'b0;
  logic                       s_ready;
  logic [63:0]                s_data = '0;  // load_pattern
  logic                       s_user = 1'b0;  // kind
  logic                       m_valid;
  logic                       m_ready = 1'b0;
  // pattern_out, first_flip, second_flip, status, at_start, zero pad
  logic [79:0]                m_data;
  int                         errors;
  int                         pending;
  int                         sent = 0;
  int                         cycles = 0;
  bit                         calm = 1'b0;
  bit                         squeeze_req = 1'b0;

  always #10 clk_i = ~clk_i;

  combination_gray_code_stepper_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (s_data),
    .s_axis_tuser  (s_user),
    .m_axis_tvalid (m_valid),
    .m_axis_tready (m_ready),
    .m_axis_tdata  (m_data)
  );

  cgs_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (s_valid),
    .in_ready_i  (s_ready),
    .in_data_i   (s_data),
    .in_user_i   (s_user),
    .out_valid_i (m_valid),
    .out_ready_i (m_ready),
    .out_data_i  (m_data),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) begin
      return 0;
    end
    if (r < 90) begin
      return $urandom_range(1, 3);
    end
    if (r < 98) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] wide_rand();
    return {$urandom, $urandom};
  endfunction

  // m ones among the low n positions, random bits above the pool
  function automatic logic [63:0] combo_pattern(input int n, input int m);
    logic [63:0] p;
    int          span;
    int          placed;
    int          pos;
    span   = (n > 64) ? 64 : n;
    p      = (span < 64) ? (wide_rand() & ({64{1'b1}} << span)) : '0;
    placed = 0;
    while (placed < m && placed < span) begin
      pos = $urandom_range(0, span - 1);
      if (!p[pos]) begin
        p[pos] = 1'b1;
        placed++;
      end
    end
    return p;
  endfunction

  task automatic write_reg(input logic idx, input int val);
    @(posedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= cgs_pkg::CountW'(val);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic setup(input int n, input int m);
    write_reg(cgs_tb_pkg::RegSetSize, n);
    write_reg(cgs_tb_pkg::RegChooseCount, m);
  endtask

  task automatic send_item(input logic kind, input logic [63:0] pat);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_user  <= kind;
    s_data  <= pat;
    do @(posedge clk_i); while (!s_ready);
    sent++;
  endtask

  // called right after the last input transfer
  task automatic drain();
    s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int hold;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (squeeze_req) begin
        squeeze_req = 1'b0;
        hold = 400;
      end else begin
        hold = idle_len();
      end
      if (hold > 0) begin
        m_ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      m_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  initial begin
    while (cycles < Limit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("combination_gray_code_stepper_top regression: fail");
    $finish;
  end

  initial begin
    int n;
    int m;
    int r;
    int len;
    int phase;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: pool 25, one chosen bit
    send_item(cgs_pkg::KindAdvance, '1);
    send_item(cgs_pkg::KindLoad, '1);
    send_item(cgs_pkg::KindLoad, 64'(1) << 24);
    send_item(cgs_pkg::KindAdvance, '0);
    send_item(cgs_pkg::KindAdvance, wide_rand());
    drain();
    setup(64, 1);
    send_item(cgs_pkg::KindLoad, '1);
    send_item(cgs_pkg::KindLoad, 64'(1) << 63);
    send_item(cgs_pkg::KindAdvance, '1);
    drain();
    write_reg(cgs_tb_pkg::RegChooseCount, 0);
    send_item(cgs_pkg::KindAdvance, '0);
    drain();
    write_reg(cgs_tb_pkg::RegChooseCount, 64);
    send_item(cgs_pkg::KindLoad, '1);
    send_item(cgs_pkg::KindAdvance, '0);
    drain();
    setup(127, 1);
    send_item(cgs_pkg::KindLoad, '1);
    send_item(cgs_pkg::KindAdvance, '0);
    drain();
    write_reg(cgs_tb_pkg::RegChooseCount, 127);
    send_item(cgs_pkg::KindAdvance, '1);
    drain();
    setup(0, 0);
    send_item(cgs_pkg::KindLoad, '1);
    send_item(cgs_pkg::KindAdvance, '0);
    drain();
    setup(6, 2);
    send_item(cgs_pkg::KindLoad, 64'h3);
    repeat (3) send_item(cgs_pkg::KindAdvance, wide_rand());
    drain();
    write_reg(cgs_tb_pkg::RegChooseCount, 3);
    send_item(cgs_pkg::KindLoad, 64'h7);
    repeat (3) send_item(cgs_pkg::KindAdvance, wide_rand());
    drain();

    phase = 0;
    while (sent < Items) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        n = $urandom_range(2, 12);
        m = $urandom_range(1, n - 1);
      end else if (r < 85) begin
        n = $urandom_range(13, 64);
        m = $urandom_range(1, n - 1);
      end else if (r < 90) begin
        n = 64;
        case ($urandom_range(0, 3))
          0: m = 1;
          1: m = 2;
          2: m = 62;
          default: m = 63;
        endcase
      end else begin
        n = $urandom_range(0, 127);
        m = $urandom_range(0, 127);
      end
      setup(n, m);
      calm = ($urandom_range(0, 5) == 0);
      if (phase == 3) begin
        squeeze_req = 1'b1;
      end
      if ($urandom_range(0, 4) != 0) begin
        send_item(cgs_pkg::KindLoad, combo_pattern(n, m));
      end
      len = $urandom_range(15, 40);
      repeat (len) begin
        r = $urandom_range(0, 99);
        if (r < 90) begin
          send_item(cgs_pkg::KindAdvance, wide_rand());
        end else if (r < 95) begin
          send_item(cgs_pkg::KindLoad, combo_pattern(n, m));
        end else begin
          send_item(cgs_pkg::KindLoad, wide_rand());
        end
      end
      drain();
      phase++;
    end

    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("combination_gray_code_stepper_top regression: pass");
    end else begin
      $display("combination_gray_code_stepper_top regression: fail");
    end
    $finish;
  end

endmodule
